### rtl/core/tzsp_pkg.sv
// Shared types, character codes and phase/status codes for the time zone
// string offset parser. No dependencies.
package tzsp_pkg;

  // Parser phase codes
  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_NAME   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_NAME  = 2'd1;
  localparam logic [1:0] ST_NO_DIGITS = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // Offset component weights and limits
  localparam int unsigned WEIGHT_HOUR = 3600;
  localparam int unsigned WEIGHT_MIN  = 60;
  localparam logic [15:0] COMP_MAX    = 16'hFFFF;
  localparam logic [7:0]  NAME_MAX    = 8'hFF;
  localparam logic [7:0]  MIN_NAME    = 8'd3;
  localparam logic [1:0]  LAST_COMP   = 2'd2;

  localparam int unsigned OFFSET_W = 29;
  localparam int unsigned TOTAL_W  = 28;

  typedef struct packed {
    logic [1:0]         phase;
    logic               in_brackets;
    logic [7:0]         name_count;
    logic               negative;
    logic [15:0]        comp_value;
    logic [1:0]         comp_index;
    logic               digit_seen;
    logic [TOTAL_W-1:0] offset_total;
  } tzsp_state_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [OFFSET_W-1:0] offset_seconds;
    logic [7:0]          name_length;
  } tzsp_result_t;

  function automatic tzsp_state_t clear_state();
    tzsp_state_t s;
    s.phase        = PH_START;
    s.in_brackets  = 1'b0;
    s.name_count   = 8'd0;
    s.negative     = 1'b0;
    s.comp_value   = 16'd0;
    s.comp_index   = 2'd0;
    s.digit_seen   = 1'b0;
    s.offset_total = '0;
    return s;
  endfunction

endpackage

### rtl/core/tzsp_step.sv
// Per-character next-state and result logic of the time zone string parser.
// Depends on tzsp_pkg.
module tzsp_step (
  input  tzsp_pkg::tzsp_state_t  state_i,
  input  logic [7:0]             ch_i,
  output tzsp_pkg::tzsp_state_t  state_o,
  output logic                   emit_o,
  output tzsp_pkg::tzsp_result_t result_o
);

  logic                        is_alpha;
  logic                        is_digit;
  logic                        is_sign;
  logic                        name_path;
  logic [7:0]                  name_inc;
  logic [19:0]                 digit_acc;
  logic [15:0]                 digit_sat;
  logic [tzsp_pkg::TOTAL_W-1:0] comp_prod;
  logic [tzsp_pkg::TOTAL_W-1:0] total_sum;
  logic [tzsp_pkg::OFFSET_W-1:0] total_ext;
  tzsp_pkg::tzsp_state_t       emit_state;

  assign is_alpha = ch_i inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  assign is_digit = ch_i inside {[8'h30:8'h39]};
  assign is_sign  = (ch_i == tzsp_pkg::CH_PLUS) || (ch_i == tzsp_pkg::CH_MINUS);

  // Saturating name count
  assign name_inc = (state_i.name_count == tzsp_pkg::NAME_MAX) ?
                    state_i.name_count : state_i.name_count + 8'd1;

  // value * 10 + digit, saturating
  assign digit_acc = 20'({state_i.comp_value, 3'b000}) + 20'({state_i.comp_value, 1'b0})
                   + 20'(ch_i[3:0]);
  assign digit_sat = (digit_acc > 20'(tzsp_pkg::COMP_MAX)) ? tzsp_pkg::COMP_MAX
                                                          : digit_acc[15:0];

  always_comb begin
    case (state_i.comp_index)
      2'd0:    comp_prod = tzsp_pkg::TOTAL_W'(state_i.comp_value)
                         * tzsp_pkg::TOTAL_W'(tzsp_pkg::WEIGHT_HOUR);
      2'd1:    comp_prod = tzsp_pkg::TOTAL_W'(state_i.comp_value)
                         * tzsp_pkg::TOTAL_W'(tzsp_pkg::WEIGHT_MIN);
      default: comp_prod = tzsp_pkg::TOTAL_W'(state_i.comp_value);
    endcase
  end

  assign total_sum = state_i.offset_total + comp_prod;
  assign total_ext = {1'b0, total_sum};

  // State after a decision: cleared, re-armed at once on NUL
  always_comb begin
    emit_state = tzsp_pkg::clear_state();
    emit_state.phase = (ch_i == tzsp_pkg::CH_NUL) ? tzsp_pkg::PH_START : tzsp_pkg::PH_DONE;
  end

  assign name_path = (state_i.phase == tzsp_pkg::PH_NAME) ||
                     ((state_i.phase == tzsp_pkg::PH_START) && (ch_i != tzsp_pkg::CH_COMMA));

  always_comb begin
    state_o                 = state_i;
    emit_o                  = 1'b0;
    result_o.status         = tzsp_pkg::ST_OK;
    result_o.offset_seconds = '0;
    result_o.name_length    = state_i.name_count;

    if (state_i.phase == tzsp_pkg::PH_START) begin
      state_o.phase = tzsp_pkg::PH_NAME;
    end

    if (name_path) begin
      if (ch_i == tzsp_pkg::CH_LT) begin
        state_o.in_brackets = 1'b1;
        state_o.name_count  = name_inc;
      end else if (ch_i == tzsp_pkg::CH_GT) begin
        state_o.in_brackets = 1'b0;
        state_o.name_count  = name_inc;
      end else if (is_alpha) begin
        state_o.name_count = name_inc;
      end else if (is_sign || is_digit) begin
        if (state_i.in_brackets) begin
          state_o.name_count = name_inc;
        end else if (state_i.name_count < tzsp_pkg::MIN_NAME) begin
          emit_o          = 1'b1;
          result_o.status = tzsp_pkg::ST_BAD_NAME;
          state_o         = emit_state;
        end else begin
          state_o.phase = tzsp_pkg::PH_DIGITS;
          if (is_digit) begin
            state_o.comp_value = digit_sat;
            state_o.digit_seen = 1'b1;
          end else begin
            state_o.negative = (ch_i == tzsp_pkg::CH_MINUS);
          end
        end
      end else begin
        emit_o          = 1'b1;
        result_o.status = tzsp_pkg::ST_BAD_NAME;
        state_o         = emit_state;
      end
    end else if (state_i.phase == tzsp_pkg::PH_DIGITS) begin
      if (is_digit) begin
        state_o.comp_value = digit_sat;
        state_o.digit_seen = 1'b1;
      end else if (!state_i.digit_seen) begin
        emit_o          = 1'b1;
        result_o.status = tzsp_pkg::ST_NO_DIGITS;
        state_o         = emit_state;
      end else if ((ch_i == tzsp_pkg::CH_COLON) &&
                   (state_i.comp_index < tzsp_pkg::LAST_COMP)) begin
        state_o.offset_total = total_sum;
        state_o.comp_index   = state_i.comp_index + 2'd1;
        state_o.comp_value   = 16'd0;
        state_o.digit_seen   = 1'b0;
      end else begin
        emit_o                  = 1'b1;
        result_o.status         = tzsp_pkg::ST_OK;
        result_o.offset_seconds = state_i.negative ? (~total_ext + 29'd1) : total_ext;
        state_o                 = emit_state;
      end
    end else if (state_i.phase == tzsp_pkg::PH_DONE) begin
      // Drop characters until the terminating NUL
      if (ch_i == tzsp_pkg::CH_NUL) begin
        state_o = tzsp_pkg::clear_state();
      end
    end
  end

endmodule

### rtl/core/tz_string_offset_parser.sv
// Time zone string parser: one character per transfer in, one result per string out.
// Each character is registered on input, and each result is registered on output.
// Throughput: one character per cycle unless the result stream stalls, with a
//   combinational update (a constant multiply, a 28-bit add on the component path).
// Reset (rst_ni low, asynchronous): parser back to start of string, both stages empty.
// Depends on tzsp_pkg and tzsp_step.
module tz_string_offset_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [1:0] status, [30:2] offset_seconds,
                                        // [38:31] name_length, [39] zero
);

  // Input register
  logic                   in_valid_q;
  logic [7:0]             ch_q;

  // Parser state
  tzsp_pkg::tzsp_state_t  state_q;
  tzsp_pkg::tzsp_state_t  state_d;

  // Result register
  logic                   out_valid_q;
  tzsp_pkg::tzsp_result_t result_q;
  tzsp_pkg::tzsp_result_t result_d;

  logic                   emit;
  logic                   advance;
  logic                   in_xfer;

  // Process the held character whenever the result register can take a result
  assign advance = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  tzsp_step u_step (
    .state_i  (state_q),
    .ch_i     (ch_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (result_d)
  );

  // Hold the incoming character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ch_q <= s_axis_tdata_i;
    end
  end

  // Advance the parser state one character at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tzsp_pkg::clear_state();
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: load on a deciding character, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, result_q.name_length, result_q.offset_seconds,
                            result_q.status};

  // Only accepted results carry a nonzero offset
  a_offset_zero_on_error : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (result_q.status == tzsp_pkg::ST_OK) || (result_q.offset_seconds == '0))
    else $error("nonzero offset on a rejected string");

  // Status code three is never produced
  a_status_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (result_q.status != 2'd3))
    else $error("illegal status code");

  // Offset parsing starts only after a name long enough
  a_digits_need_name : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == tzsp_pkg::PH_DIGITS) |-> (state_q.name_count >= tzsp_pkg::MIN_NAME))
    else $error("offset phase with short name");

  // At most hours, minutes and seconds
  a_comp_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.comp_index != 2'd3)
    else $error("component index out of range");

endmodule

### tb/tb.sv
// Self-checking testbench for tz_string_offset_parser: directed zone strings, then random ones.
// Depends on tzsp_pkg for status and character codes, and on the parser RTL.
`timescale 1ns / 1ps

module tb;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam int unsigned WEIGHT_SEC = 1;
  localparam int TOTAL_CHARS = 1550;
  localparam int DRAIN_CYCLES = 20;

  // One character waiting to go out, with an optional hand-typed result for its string
  typedef struct {
    logic [7:0]             ch;
    bit                     pinned;
    tzsp_pkg::tzsp_result_t pinned_res;
  } feed_t;

  // One directed zone string; the NUL terminator is appended when the row is queued
  typedef struct {
    string      text;
    bit         pinned;
    logic [1:0] st;
    int         off;
    int         len;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'd0;
  logic        m_rdy = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;

  feed_t                  char_fifo[$];
  tzsp_pkg::tzsp_result_t pending_results[$];
  int           err_count = 0;
  int           tx_calm = 0;
  int           rx_calm = 0;
  int           rx_hold = 0;

  // Parser shadow state
  logic [1:0]  stage;
  bit          bracket_open;
  logic [7:0]  name_len;
  bit          minus;
  int unsigned comp_val;
  logic [1:0]  comp_idx;
  bit          have_digit;
  int unsigned total;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tz_string_offset_parser u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_rdy),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void restart_string();
    stage        = tzsp_pkg::PH_START;
    bracket_open = 1'b0;
    name_len     = 8'd0;
    minus        = 1'b0;
    comp_val     = 0;
    comp_idx     = 2'd0;
    have_digit   = 1'b0;
    total        = 0;
  endfunction

  function automatic void bump_name();
    if (name_len != tzsp_pkg::NAME_MAX) name_len++;
  endfunction

  function automatic void add_digit(input logic [7:0] c);
    int unsigned v;
    v = comp_val * 10 + (c - CH_ZERO);
    comp_val = (v > tzsp_pkg::COMP_MAX) ? tzsp_pkg::COMP_MAX : v;
    have_digit = 1'b1;
  endfunction

  // Advance the shadow parser by one character; return 1 when the string is decided
  function automatic bit parse_char(input logic [7:0] c, output tzsp_pkg::tzsp_result_t r);
    logic [1:0]  st;
    logic [28:0] mag;
    int unsigned weight;
    r = '0;
    st = tzsp_pkg::ST_OK;
    if (stage == tzsp_pkg::PH_DONE) begin
      if (c == tzsp_pkg::CH_NUL) restart_string();
      return 1'b0;
    end
    if (stage == tzsp_pkg::PH_START) begin
      // drop one leading comma, otherwise treat the character as part of the name
      stage = tzsp_pkg::PH_NAME;
      if (c == tzsp_pkg::CH_COMMA) return 1'b0;
    end
    if (stage == tzsp_pkg::PH_NAME) begin
      if (c == tzsp_pkg::CH_LT || c == tzsp_pkg::CH_GT) begin
        bracket_open = (c == tzsp_pkg::CH_LT);
        bump_name();
        return 1'b0;
      end
      if (is_letter(c)) begin
        bump_name();
        return 1'b0;
      end
      if (c == tzsp_pkg::CH_PLUS || c == tzsp_pkg::CH_MINUS || is_num(c)) begin
        if (bracket_open) begin
          bump_name();
          return 1'b0;
        end
        if (name_len < tzsp_pkg::MIN_NAME) begin
          st = tzsp_pkg::ST_BAD_NAME;
        end else begin
          stage = tzsp_pkg::PH_DIGITS;
          if (is_num(c)) add_digit(c);
          else minus = (c == tzsp_pkg::CH_MINUS);
          return 1'b0;
        end
      end else begin
        st = tzsp_pkg::ST_BAD_NAME;
      end
    end else begin
      if (is_num(c)) begin
        add_digit(c);
        return 1'b0;
      end
      if (!have_digit) begin
        st = tzsp_pkg::ST_NO_DIGITS;
      end else begin
        case (comp_idx)
          2'd0:    weight = tzsp_pkg::WEIGHT_HOUR;
          2'd1:    weight = tzsp_pkg::WEIGHT_MIN;
          default: weight = WEIGHT_SEC;
        endcase
        total += comp_val * weight;
        if (c == tzsp_pkg::CH_COLON && comp_idx < tzsp_pkg::LAST_COMP) begin
          comp_idx++;
          comp_val = 0;
          have_digit = 1'b0;
          return 1'b0;
        end
      end
    end
    mag = total[28:0];
    r.status         = st;
    r.offset_seconds = (st != tzsp_pkg::ST_OK) ? '0 : (minus ? 29'd0 - mag : mag);
    r.name_length    = name_len;
    restart_string();
    // a deciding NUL re-arms at once; anything else waits for the NUL
    stage = (c == tzsp_pkg::CH_NUL) ? tzsp_pkg::PH_START : tzsp_pkg::PH_DONE;
    return 1'b1;
  endfunction

  function automatic void queue_char(input logic [7:0] c, input bit pinned,
                                     input tzsp_pkg::tzsp_result_t r);
    feed_t f;
    f.ch = c;
    f.pinned = pinned;
    f.pinned_res = r;
    char_fifo.push_back(f);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_bracket_char();
    case ($urandom_range(0, 3))
      0:       return tzsp_pkg::CH_PLUS;
      1:       return tzsp_pkg::CH_MINUS;
      2:       return 8'(CH_ZERO + $urandom_range(0, 9));
      default: return rand_letter();
    endcase
  endfunction

  // Gap length: mostly none or short, a few long, with calm stretches of no gaps at all
  function automatic int pause_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Queue random strings: mostly well-formed name plus offset, some broken, some noise
  task automatic add_random_strings(input int target);
    logic [7:0]             txt[$];
    tzsp_pkg::tzsp_result_t none;
    int           kind, ncomp, ndig, pos;
    none = '0;
    while (char_fifo.size() < target) begin
      txt.delete();
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        repeat ($urandom_range(0, 12)) txt.push_back(8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 3) == 0) txt.push_back(tzsp_pkg::CH_COMMA);
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
          repeat ($urandom_range(0, 2)) txt.push_back(rand_letter());
        end else if (kind < 9) begin
          repeat ($urandom_range(250, 262)) txt.push_back(rand_letter());
        end else if (kind < 35) begin
          txt.push_back(tzsp_pkg::CH_LT);
          repeat ($urandom_range(1, 6)) txt.push_back(rand_bracket_char());
          txt.push_back(tzsp_pkg::CH_GT);
        end else begin
          repeat ($urandom_range(3, 6)) txt.push_back(rand_letter());
        end
        case ($urandom_range(0, 2))
          1:       txt.push_back(tzsp_pkg::CH_PLUS);
          2:       txt.push_back(tzsp_pkg::CH_MINUS);
          default: ;
        endcase
        ncomp = $urandom_range(1, 3);
        for (int k = 0; k < ncomp; k++) begin
          if (k != 0) txt.push_back(tzsp_pkg::CH_COLON);
          // long digit runs push components into saturation
          ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2);
          repeat (ndig) txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        if (ncomp == 3 && $urandom_range(0, 3) == 0) txt.push_back(tzsp_pkg::CH_COLON);
        // break about one string in five
        if ($urandom_range(0, 4) == 0) begin
          pos = $urandom_range(0, txt.size() - 1);
          case ($urandom_range(0, 2))
            0:       txt.insert(pos, 8'($urandom_range(1, 255)));
            1:       txt.insert(pos, CH_SPACE);
            default: txt.delete(pos);
          endcase
        end
        // random trailing characters before the terminating NUL
        if ($urandom_range(0, 1))
          repeat ($urandom_range(1, 5)) txt.push_back(8'($urandom_range(1, 255)));
      end
      foreach (txt[i]) queue_char(txt[i], 1'b0, none);
      queue_char(tzsp_pkg::CH_NUL, 1'b0, none);
    end
  endtask

  // Receiver: stall tready at random
  always @(posedge clk_i) begin
    int n;
    if (rx_hold > 0) begin
      rx_hold--;
      m_rdy <= 1'b0;
    end else begin
      n = pause_len(rx_calm);
      m_rdy <= (n == 0);
      if (n != 0) rx_hold = n - 1;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    tzsp_pkg::tzsp_result_t want;
    tzsp_pkg::tzsp_result_t got;
    if (rst_n && m_axis_tvalid_o && m_rdy) begin
      got.status         = m_axis_tdata_o[1:0];
      got.offset_seconds = m_axis_tdata_o[30:2];
      got.name_length    = m_axis_tdata_o[38:31];
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("tb: unexpected result status=%0d offset=%0d len=%0d",
                   got.status, $signed(got.offset_seconds), got.name_length);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.offset_seconds != want.offset_seconds ||
            got.name_length != want.name_length) begin
          err_count++;
          if (err_count <= 10)
            $display("tb: mismatch exp status=%0d offset=%0d len=%0d, got %0d %0d %0d",
                     want.status, $signed(want.offset_seconds), want.name_length,
                     got.status, $signed(got.offset_seconds), got.name_length);
        end
      end
    end
  end

  initial begin
    row_t                   dir_rows[22];
    string                  long_name;
    tzsp_pkg::tzsp_result_t res;
    int           gap;
    int           off;

    restart_string();
    long_name = "";
    for (int i = 0; i < 140; i++) long_name = {long_name, "Zz"};

    // Directed strings; results typed in only where obvious
    dir_rows = '{
      '{"",                      1'b1, tzsp_pkg::ST_BAD_NAME,  0,          0},
      '{"\377",                  1'b1, tzsp_pkg::ST_BAD_NAME,  0,          0},
      '{"EST5",                  1'b1, tzsp_pkg::ST_OK,        18000,      3},
      '{"AB5",                   1'b1, tzsp_pkg::ST_BAD_NAME,  0,          2},
      '{"ABC+",                  1'b1, tzsp_pkg::ST_NO_DIGITS, 0,          3},
      '{"ABC-99999:99999:99999", 1'b1, tzsp_pkg::ST_OK,        -239923635, 3},
      '{"ABC+99999:99999:99999", 1'b1, tzsp_pkg::ST_OK,        239923635,  3},
      '{{long_name, "-1"},       1'b1, tzsp_pkg::ST_OK,        -3600,      255},
      '{",PST8PDT,M3.2.0",       1'b0, tzsp_pkg::ST_OK,        0,          0},
      '{",,ABC1",                1'b0, tzsp_pkg::ST_OK,        0,          0},
      '{"<+0530>-5:30",          1'b0, tzsp_pkg::ST_OK,        0,          0},
      '{"<UTC",                  1'b0, tzsp_pkg::ST_OK,        0,          0},
      '{"ABC1:",                 1'b0, tzsp_pkg::ST_OK,        0,          0},
      '{"ABC1: 5",               1'b0, tzsp_pkg::ST_OK,        0,          0},
      '{"ABC1:2:3:4",            1'b0, tzsp_pkg::ST_OK,        0,          0},
      '{"ABC--1",                1'b0, tzsp_pkg::ST_OK,        0,          0},
      '{"ABC 1",                 1'b0, tzsp_pkg::ST_OK,        0,          0},
      '{"AB>C<D-0",              1'b0, tzsp_pkg::ST_OK,        0,          0},
      '{"abcxyz-12junk",         1'b0, tzsp_pkg::ST_OK,        0,          0},
      '{"ABC0",                  1'b0, tzsp_pkg::ST_OK,        0,          0},
      '{"ABC\1771",              1'b0, tzsp_pkg::ST_OK,        0,          0},
      '{"ABC1\200",              1'b0, tzsp_pkg::ST_OK,        0,          0}
    };
    foreach (dir_rows[i]) begin
      off = dir_rows[i].off;
      res.status         = dir_rows[i].st;
      res.offset_seconds = off[28:0];
      res.name_length    = dir_rows[i].len[7:0];
      for (int k = 0; k < dir_rows[i].text.len(); k++)
        queue_char(dir_rows[i].text[k], dir_rows[i].pinned, res);
      queue_char(tzsp_pkg::CH_NUL, dir_rows[i].pinned, res);
    end
    // fill up with random strings to the total character count
    add_random_strings(TOTAL_CHARS);

    // Hold reset, then release it at a clock edge
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;

    while (char_fifo.size() != 0) begin
      gap = pause_len(tx_calm);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_valid <= 1'b1;
      s_data  <= char_fifo[0].ch;
      do @(posedge clk_i); while (!s_axis_tready_o);
      // transfer taken at this edge: predict its result
      if (parse_char(char_fifo[0].ch, res)) begin
        if (char_fifo[0].pinned) res = char_fifo[0].pinned_res;
        pending_results.push_back(res);
      end
      void'(char_fifo.pop_front());
    end
    s_valid <= 1'b0;

    // Drain: wait for every expected result, then watch for strays
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

### sim.f
rtl/core/tzsp_pkg.sv
rtl/core/tzsp_step.sv
rtl/core/tz_string_offset_parser.sv
tb/tb.sv
